/* hw/rtl/ema_pkg.sv */
// Shared types and constants for the error metric accumulator.
// No dependencies; imported by ema_ctrl, ema_dpath and error_metric_accumulator.
package ema_pkg;

    localparam int METRIC_W = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int ROOT_W   = 64;

    // metric_select codes
    localparam logic [METRIC_W-1:0] MET_REL_RMSE = 2'd0;
    localparam logic [METRIC_W-1:0] MET_RMSE     = 2'd1;
    localparam logic [METRIC_W-1:0] MET_MAE      = 2'd2;
    localparam logic [METRIC_W-1:0] MET_R2       = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    // products run through the shared multiplier for R2
    localparam logic [1:0] MUL_NQ  = 2'd0;  // N * Q
    localparam logic [1:0] MUL_SS  = 2'd1;  // |S| * |S|
    localparam logic [1:0] MUL_NSD = 2'd2;  // N * sd

    localparam logic [VALUE_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [ROOT_W-1:0]  R2_Q_MAX  = 64'h0000_0000_8001_0000;
    localparam logic [ROOT_W-1:0]  ROOT_BIT0 = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic       acc;      // accumulate the accepted pair
        logic       clr;      // clear count and sums
        logic       mul_ld;
        logic       mul_run;
        logic [1:0] mul_idx;
        logic       div_ld;
        logic       div_run;
        logic       sq_ld;
        logic       sq_run;
        logic       out_ld;   // load the result register
    } ema_cmd_t;

    typedef struct packed {
        logic [METRIC_W-1:0] sel;
        logic                zero;
        logic                mul_done;
        logic                div_done;
        logic                sq_done;
    } ema_stat_t;

endpackage

/* hw/rtl/error_metric_accumulator.sv */
// Top level of the error metric accumulator: stream ports, config register port.
// Depends on ema_pkg, ema_ctrl and ema_dpath.

// Takes (reference, test) sample pairs and keeps a pair count plus running sums of
// squared differences, absolute differences, reference values and squared reference
// values. Pairs without tlast are taken one per cycle. On the tlast pair the block
// stops taking requests and works out the metric picked by the config register
// (0 relative RMSE, 1 RMSE, 2 MAE, 3 R2) as signed Q16.16 with a status in tuser
// (0 ok, 1 zero denominator with value 0, 2 saturated), then clears the sums.
// Unless the denominator is zero, the final pass runs a restoring divider, one
// quotient bit a cycle over a NUM_W-bit numerator (113 bits at default parameters);
// both RMSE metrics then take a root, two radicand bits a cycle, and R2 first runs
// three products on a shift-add multiplier whose A_W-bit operand is as wide as the
// reference sum (40 bits at default parameters). A finished result then waits in
// the output register; pairs are taken meanwhile until a second result has to wait.
module error_metric_accumulator import ema_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input pairs
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // ref_sample, test_sample
    input  logic                               s_tlast,  // last_item
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [VALUE_W-1:0]                 m_tdata,  // metric_value
    output logic [STATUS_W-1:0]                m_tuser,  // status
    // metric_select register
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [METRIC_W-1:0]                cfg_data
);

    ema_cmd_t  cmd;
    ema_stat_t stat;

    // register writes are captured in the select register, always ready
    assign cfg_ready = 1'b1;

    ema_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // padding bits above the two samples are ignored
    ema_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .ref_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .test_sample  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .metric_value (m_tdata),
        .status       (m_tuser)
    );

`ifndef SYNTHESIS
    // after the last pair of a set no further request is taken until the result is out
    a_hold_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("pair accepted during metric computation");

    // a zero denominator always reports value zero
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_ZERO) |-> (m_tdata == '0))
        else $error("zero denominator with nonzero value");

    // no undefined status code leaves the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO || m_tuser == ST_SAT))
        else $error("bad status code");
`endif

endmodule

/* hw/rtl/ema_ctrl.sv */
// Sequencer for the error metric accumulator: accept, multiply, divide, root, output.
// Depends on ema_pkg.
module ema_ctrl import ema_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  logic      m_tready,
    output logic      m_tvalid,
    input  ema_stat_t stat,
    output ema_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_MUL_LD  = 4'd2;
    localparam logic [3:0] S_MUL_RUN = 4'd3;
    localparam logic [3:0] S_DIV_LD  = 4'd4;
    localparam logic [3:0] S_DIV_RUN = 4'd5;
    localparam logic [3:0] S_SQ_LD   = 4'd6;
    localparam logic [3:0] S_SQ_RUN  = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.mul_idx = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.acc = 1'b1;
                    if (s_tlast) state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                idx_next = MUL_NQ;
                if (stat.sel == MET_R2) state_next = S_MUL_LD;
                else if (stat.zero)     state_next = S_OUT;
                else                    state_next = S_DIV_LD;
            end
            S_MUL_LD: begin
                cmd.mul_ld = 1'b1;
                state_next = S_MUL_RUN;
            end
            S_MUL_RUN: begin
                cmd.mul_run = 1'b1;
                if (stat.mul_done) begin
                    if (idx_reg == MUL_NSD) begin
                        // N*Q and S*S are stored by now
                        state_next = stat.zero ? S_OUT : S_DIV_LD;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_MUL_LD;
                    end
                end
            end
            S_DIV_LD: begin
                cmd.div_ld = 1'b1;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                cmd.div_run = 1'b1;
                if (stat.div_done) begin
                    if (stat.sel inside {MET_REL_RMSE, MET_RMSE}) state_next = S_SQ_LD;
                    else                                           state_next = S_OUT;
                end
            end
            S_SQ_LD: begin
                cmd.sq_ld  = 1'b1;
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                cmd.sq_run = 1'b1;
                if (stat.sq_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_ld = 1'b1;
                    cmd.clr    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_ld)     out_valid_next = 1'b1;
        else if (m_tready)  out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= MUL_NQ;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/ema_dpath.sv */
// Datapath: accumulators, shift-add multiplier, restoring divider, bitwise root, result reg.
// Depends on ema_pkg; driven by ema_ctrl commands.
module ema_dpath import ema_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ema_cmd_t               cmd,
    output ema_stat_t              stat,
    input  logic                   cfg_valid,
    input  logic [METRIC_W-1:0]    cfg_data,
    input  logic [SAMPLE_BITS-1:0] ref_sample,
    input  logic [SAMPLE_BITS-1:0] test_sample,
    output logic [VALUE_W-1:0]     metric_value,
    output logic [STATUS_W-1:0]    status
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CNT_W = COUNT_BITS + 1;
    localparam int SQD_R = 2 * SB + COUNT_BITS + 1;
    localparam int ABS_R = SB + COUNT_BITS + 1;
    localparam int RS_R  = SB + COUNT_BITS;
    localparam int RSQ_R = 2 * SB + COUNT_BITS - 1;
    localparam int SQD_W = (SQD_R > 64) ? 64 : SQD_R;
    localparam int ABS_W = (ABS_R > 64) ? 64 : ABS_R;
    localparam int RS_W  = (RS_R  > 64) ? 64 : RS_R;
    localparam int RSQ_W = (RSQ_R > 64) ? 64 : RSQ_R;
    localparam int A_W   = (RS_W > CNT_W) ? RS_W : CNT_W;
    localparam int B_T   = (RSQ_W > RS_W) ? RSQ_W : RS_W;
    localparam int B_W   = (SQD_W > B_T) ? SQD_W : B_T;
    localparam int MUL_W = A_W + B_W;
    localparam int DEN_W = MUL_W;
    localparam int N_T1  = (MUL_W + 16 > SQD_W + 32) ? MUL_W + 16 : SQD_W + 32;
    localparam int N_T2  = (N_T1 > ABS_W + 16) ? N_T1 : ABS_W + 16;
    localparam int NUM_W = (N_T2 > ROOT_W) ? N_T2 : ROOT_W;
    localparam int DC_W  = $clog2(NUM_W + 1);

    // accumulators
    logic [CNT_W-1:0] cnt_reg;
    logic [SQD_W-1:0] sqd_reg;
    logic [ABS_W-1:0] absd_reg;
    logic [RS_W-1:0]  rs_reg;
    logic [RSQ_W-1:0] rsq_reg;
    logic [METRIC_W-1:0] sel_reg;

    logic signed [SB:0] diff;
    logic [SB:0]        ad;
    logic [SB-1:0]      ma;
    logic [2*SB+1:0]    ad_sq;
    logic [2*SB-1:0]    ma_sq;
    logic [RS_W-1:0]    ms;

    assign diff  = $signed({ref_sample[SB-1], ref_sample})
                 - $signed({test_sample[SB-1], test_sample});
    assign ad    = diff[SB] ? (~diff + 1'b1) : diff;
    assign ma    = ref_sample[SB-1] ? (~ref_sample + 1'b1) : ref_sample;
    assign ad_sq = ad * ad;
    assign ma_sq = ma * ma;
    assign ms    = rs_reg[RS_W-1] ? (~rs_reg + 1'b1) : rs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= MET_REL_RMSE;
        end else if (cfg_valid) begin
            sel_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr) begin
            cnt_reg  <= '0;
            sqd_reg  <= '0;
            absd_reg <= '0;
            rs_reg   <= '0;
            rsq_reg  <= '0;
        end else if (cmd.acc && !cnt_reg[CNT_W-1]) begin
            // count saturates at 2^COUNT_BITS; later pairs are dropped
            cnt_reg  <= cnt_reg + 1'b1;
            sqd_reg  <= sqd_reg + SQD_W'(ad_sq);
            absd_reg <= absd_reg + ABS_W'(ad);
            rs_reg   <= rs_reg + RS_W'($signed(ref_sample));
            rsq_reg  <= rsq_reg + RSQ_W'(ma_sq);
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    logic [A_W-1:0]   mul_a_reg;
    logic [MUL_W-1:0] mul_b_reg, mul_acc_reg;
    logic [MUL_W-1:0] nq_reg, s2_reg, nsd_reg;
    logic             mul_done;

    assign mul_done = (mul_a_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.mul_ld) begin
            mul_acc_reg <= '0;
            case (cmd.mul_idx)
                MUL_NQ: begin
                    mul_a_reg <= A_W'(cnt_reg);
                    mul_b_reg <= MUL_W'(rsq_reg);
                end
                MUL_SS: begin
                    mul_a_reg <= A_W'(ms);
                    mul_b_reg <= MUL_W'(ms);
                end
                default: begin
                    mul_a_reg <= A_W'(cnt_reg);
                    mul_b_reg <= MUL_W'(sqd_reg);
                end
            endcase
        end else if (cmd.mul_run) begin
            if (!mul_done) begin
                if (mul_a_reg[0]) mul_acc_reg <= mul_acc_reg + mul_b_reg;
                mul_a_reg <= mul_a_reg >> 1;
                mul_b_reg <= mul_b_reg << 1;
            end else begin
                case (cmd.mul_idx)
                    MUL_NQ:  nq_reg  <= mul_acc_reg;
                    MUL_SS:  s2_reg  <= mul_acc_reg;
                    default: nsd_reg <= mul_acc_reg;
                endcase
            end
        end
    end

    // restoring divider, one quotient bit per cycle; numerator shifts out of div_q_reg
    logic [NUM_W-1:0] div_q_reg;
    logic [DEN_W-1:0] div_r_reg, div_d_reg;
    logic [DC_W-1:0]  div_cnt_reg;
    logic [DEN_W:0]   rem_sh;
    logic             rem_ge;

    assign rem_sh = {div_r_reg, div_q_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_d_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_ld) begin
            div_r_reg   <= '0;
            div_cnt_reg <= DC_W'(NUM_W);
            case (sel_reg)
                MET_REL_RMSE: begin
                    div_q_reg <= NUM_W'({sqd_reg, 32'd0});
                    div_d_reg <= DEN_W'(rsq_reg);
                end
                MET_RMSE: begin
                    div_q_reg <= NUM_W'({sqd_reg, 32'd0});
                    div_d_reg <= DEN_W'(cnt_reg);
                end
                MET_MAE: begin
                    div_q_reg <= NUM_W'({absd_reg, 16'd0});
                    div_d_reg <= DEN_W'(cnt_reg);
                end
                default: begin
                    div_q_reg <= NUM_W'({nsd_reg, 16'd0});
                    div_d_reg <= nq_reg - s2_reg;
                end
            endcase
        end else if (cmd.div_run && div_cnt_reg != '0) begin
            div_r_reg   <= rem_ge ? DEN_W'(rem_sh - {1'b0, div_d_reg}) : rem_sh[DEN_W-1:0];
            div_q_reg   <= {div_q_reg[NUM_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // bitwise integer square root, two radicand bits per cycle
    logic [ROOT_W-1:0] sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [ROOT_W-1:0] sq_trial;

    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sq_ld) begin
            sq_x_reg   <= div_q_reg[ROOT_W-1:0];
            sq_res_reg <= '0;
            sq_bit_reg <= ROOT_BIT0;
        end else if (cmd.sq_run && sq_bit_reg != '0) begin
            if (sq_x_reg >= sq_trial) begin
                sq_x_reg   <= sq_x_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // result selection
    logic zero;
    logic [VALUE_W-1:0]  val_c;
    logic [STATUS_W-1:0] st_c;

    always_comb begin
        case (sel_reg)
            MET_REL_RMSE: zero = (rsq_reg == '0);
            MET_RMSE:     zero = (cnt_reg == '0);
            MET_MAE:      zero = (cnt_reg == '0);
            default:      zero = (nq_reg <= s2_reg);
        endcase
    end

    always_comb begin
        val_c = '0;
        st_c  = ST_OK;
        if (zero) begin
            st_c = ST_ZERO;
        end else begin
            case (sel_reg)
                MET_REL_RMSE, MET_RMSE: begin
                    if (|div_q_reg[NUM_W-1:62]) begin
                        val_c = SAT_POS;
                        st_c  = ST_SAT;
                    end else begin
                        val_c = sq_res_reg[VALUE_W-1:0];
                    end
                end
                MET_MAE: begin
                    if (|div_q_reg[NUM_W-1:31]) begin
                        val_c = SAT_POS;
                        st_c  = ST_SAT;
                    end else begin
                        val_c = div_q_reg[VALUE_W-1:0];
                    end
                end
                default: begin
                    if (div_q_reg > NUM_W'(R2_Q_MAX)) begin
                        val_c = SAT_NEG;
                        st_c  = ST_SAT;
                    end else begin
                        val_c = Q_ONE - div_q_reg[VALUE_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            metric_value <= val_c;
            status       <= st_c;
        end
    end

    assign stat.sel      = sel_reg;
    assign stat.zero     = zero;
    assign stat.mul_done = mul_done;
    assign stat.div_done = (div_cnt_reg == '0);
    assign stat.sq_done  = (sq_bit_reg == '0);

endmodule

/* bench/error_metric_accumulator_tb.sv */
// Self-checking bench for error_metric_accumulator: drives sample pairs and predicts each metric.
// Depends on ema_pkg and the error_metric_accumulator RTL only.
module error_metric_accumulator_tb;
    import ema_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } metric_t;

    localparam int TAIL_CYCLES = 320;  // worst final pass (R2) plus margin

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [VALUE_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [METRIC_W-1:0] cfg_data = MET_REL_RMSE;

    // predictor state
    logic [METRIC_W-1:0] metric_sel;
    logic [24:0]         pair_cnt;
    logic [56:0]         sqd_sum;
    logic [40:0]         absd_sum;
    logic [39:0]         ref_total;
    logic [54:0]         refsq_sum;

    metric_t metric_q[$];
    int      errors = 0;
    int      src_idle = 0;
    int      snk_idle = 0;
    int      stall_cycles = 0;

    error_metric_accumulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [31:0] floor_root(input logic [63:0] x);
        logic [63:0] res, bitv;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    // root of a Q32.32 quotient into Q16.16
    function automatic metric_t root_metric(input logic [127:0] q);
        metric_t r;
        if (q >= 128'h4000_0000_0000_0000) begin
            r.value = SAT_POS; r.status = ST_SAT;
        end else begin
            r.value = floor_root(q[63:0]); r.status = ST_OK;
        end
        return r;
    endfunction

    // metric at the end of a set; sums already include the last pair
    function automatic metric_t metric_of_set();
        metric_t     r;
        logic [127:0] n, s2, nq, q;
        logic [39:0]  mag;
        r.value = '0; r.status = ST_OK;
        n = 128'(pair_cnt);
        case (metric_sel)
            MET_REL_RMSE: begin
                if (refsq_sum == 0) r.status = ST_ZERO;
                else r = root_metric((128'(sqd_sum) << 32) / refsq_sum);
            end
            MET_RMSE: begin
                if (n == 0) r.status = ST_ZERO;
                else r = root_metric((128'(sqd_sum) << 32) / n);
            end
            MET_MAE: begin
                if (n == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    q = (128'(absd_sum) << 16) / n;
                    if (q > 128'(SAT_POS)) begin
                        r.value = SAT_POS; r.status = ST_SAT;
                    end else begin
                        r.value = q[31:0];
                    end
                end
            end
            default: begin
                mag = ref_total[39] ? -ref_total : ref_total;
                s2  = 128'(mag) * 128'(mag);
                nq  = n * 128'(refsq_sum);
                if (nq <= s2) begin
                    r.status = ST_ZERO;
                end else begin
                    q = ((n * 128'(sqd_sum)) << 16) / (nq - s2);
                    if (q > 128'(R2_Q_MAX)) begin
                        r.value = SAT_NEG; r.status = ST_SAT;
                    end else begin
                        r.value = Q_ONE - q[31:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic accumulate_pair(input logic signed [15:0] rs, input logic signed [15:0] ts,
                                   input bit is_last);
        int          diff;
        logic [16:0] ad;
        logic [15:0] rm;
        diff = int'(rs) - int'(ts);
        ad   = 17'(diff < 0 ? -diff : diff);
        rm   = 16'(rs < 0 ? -int'(rs) : int'(rs));
        if (pair_cnt < 25'h100_0000) begin
            sqd_sum   += 57'(ad) * 57'(ad);
            absd_sum  += 41'(ad);
            ref_total += 40'(rs);
            refsq_sum += 55'(rm) * 55'(rm);
            pair_cnt  += 25'd1;
        end
        if (is_last) begin
            metric_q.push_back(metric_of_set());
            pair_cnt = '0; sqd_sum = '0; absd_sum = '0; ref_total = '0; refsq_sum = '0;
        end
    endtask

    // one request on the input channel; caller sits just after a rising edge
    task automatic send_pair(input logic signed [15:0] rs, input logic signed [15:0] ts,
                             input bit is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, rs};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        accumulate_pair(rs, ts, is_last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (metric_q.size() != 0) @(posedge aclk);
    endtask

    // register writes only with the block idle
    task automatic set_metric(input logic [METRIC_W-1:0] m);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        metric_sel = m;
    endtask

    // receiver: random stalls, or a long hold-off when stall_cycles is set
    always @(posedge aclk) begin
        if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= snk_idle);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (metric_q.size() == 0) begin
                report_err($sformatf("unexpected result %h/%0d", m_tdata, m_tuser));
            end else begin
                metric_t e;
                e = metric_q.pop_front();
                if (m_tdata !== e.value)
                    report_err($sformatf("metric_value %h, want %h", m_tdata, e.value));
                if (m_tuser !== e.status)
                    report_err($sformatf("status %0d, want %0d", m_tuser, e.status));
            end
        end
    end

    task automatic test_directed();
        for (int m = 0; m < 4; m++) begin
            set_metric(METRIC_W'(m));
            send_pair(-16'sd32768, 16'sd32767, 1'b1);   // widest difference, saturates RMSE and MAE
            send_pair(16'sd0, 16'sd0, 1'b1);            // all-zero set: zero denominator for relative RMSE and R2
            send_pair(16'sd100, 16'sd100, 1'b0);
            send_pair(16'sd100, -16'sd100, 1'b1);       // constant reference for R2
            send_pair(16'sd32767, -16'sd32768, 1'b0);
            send_pair(-16'sd32768, -16'sd32768, 1'b1);
        end
    endtask

    // random sets; mostly test close to reference so R2 lands in range
    task automatic run_sets(input int n_items);
        int sent, len;
        logic signed [15:0] rs, ts, base;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(5) == 0)
                set_metric($urandom_range(3) == 0 ? METRIC_W'($urandom_range(3)) :
                           ($urandom_range(1) ? MET_R2 : MET_REL_RMSE));
            len  = $urandom_range(9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 16);
            base = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3))
                    0: rs = 16'($urandom);
                    1: rs = base;
                    default: rs = base + 16'($urandom_range(2000)) - 16'sd1000;
                endcase
                ts = $urandom_range(3) == 0 ? 16'($urandom)
                                            : rs + 16'($urandom_range(64)) - 16'sd32;
                send_pair(rs, ts, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_idle_phases();
        src_idle = 25; snk_idle = 49;
        run_sets(600);
        src_idle = 49; snk_idle = 25;
        run_sets(600);
        src_idle = 0;  snk_idle = 0;
        run_sets(600);
    endtask

    // long receiver hold-off fills the output register and stalls input
    task automatic test_backpressure();
        set_metric(MET_MAE);
        stall_cycles = 2000;
        for (int i = 0; i < 20; i++) begin
            send_pair(16'($urandom), 16'($urandom), 1'b0);
            send_pair(16'($urandom), 16'($urandom), 1'b1);
        end
        wait_drained();
        set_metric(MET_R2);
    endtask

    initial begin
        metric_sel = MET_REL_RMSE;
        pair_cnt = '0; sqd_sum = '0; absd_sum = '0; ref_total = '0; refsq_sum = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_idle_phases();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
